>>> rtl/pcihb_pkg.sv
// Package for the PCI host bridge register file: word map, masks, reset values and helpers.
package pcihb_pkg;

    // Byte order of the bus; when set, data is byte-swapped in and out.
    localparam bit BIG_ENDIAN = 1'b0;

    localparam int NWIN = 6;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 104;

    typedef logic [9:0]  t_word;
    typedef logic [14:0] t_low;
    typedef logic [6:0]  t_high;
    typedef logic [10:0] t_remap;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam t_word W_CPU     = 10'h000;
    localparam t_word W_SYNC0   = 10'h030;
    localparam t_word W_SYNC1   = 10'h032;
    localparam t_word W_ERR_ALO = 10'h01c;
    localparam t_word W_ERR_AHI = 10'h01e;
    localparam t_word W_ERR_DLO = 10'h04a;
    localparam t_word W_ERR_DHI = 10'h04c;
    localparam t_word W_ERR_PAR = 10'h04e;
    localparam t_word W_SDRAM0  = 10'h113;
    localparam t_word W_SDRAM3  = 10'h116;
    localparam t_word W_CMD0    = 10'h300;
    localparam t_word W_CMD1    = 10'h320;
    localparam t_word W_CFGADDR = 10'h33e;

    localparam t_word LOW_WORD   [NWIN] = '{10'h012, 10'h016, 10'h020, 10'h024, 10'h028, 10'h02c};
    localparam t_word HIGH_WORD  [NWIN] = '{10'h014, 10'h018, 10'h022, 10'h026, 10'h02a, 10'h02e};
    localparam t_word REMAP_WORD [NWIN] = '{10'h03c, 10'h03e, 10'h040, 10'h042, 10'h044, 10'h046};

    localparam t_low  LOW_RESET  [NWIN] = '{15'h080, 15'h090, 15'h790, 15'h100, 15'h110, 15'h120};
    localparam t_high HIGH_RESET [NWIN] = '{7'h0f, 7'h1f, 7'h1f, 7'h0f, 7'h1f, 7'h2f};

    localparam logic [31:0] CMD_MASK     = 32'h0401fc0f;
    localparam logic [31:0] CFGADDR_MASK = 32'h80fffffc;
    localparam logic [31:0] SYNC_VALUE   = 32'hc000ffee;
    localparam logic [31:0] ERR_DATA     = 32'hffffffff;
    localparam logic [31:0] ERR_PARITY   = 32'h000000ff;
    localparam logic [31:0] MAP_LIMIT    = 32'h10000000;
    localparam logic [31:0] SDRAM_RESET  = 32'h00000005;

    localparam logic [31:0] CPU_RESET = BIG_ENDIAN ? 32'h0 : 32'h00000800;
    localparam logic [31:0] CMD_RESET = BIG_ENDIAN ? 32'h0 : 32'h00010001;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

>>> rtl/pci_host_bridge_register_file.sv
// Register file of a PCI host bridge, one 32-bit bus access per request.
//
// Usage: a request enters on the s_axis channel; tuser carries the access kind
// (read or write) and tdata the word index and the write data. Each request
// gives exactly one response on the m_axis channel with the read data (zero for
// writes), the decode of the first IO window after the access, and a flag that
// tells whether a write touched a window decode register.
// A request is first held in the input register; the register file is read
// and updated as it moves into the output register, which holds the response
// until it is taken. Throughput is one request per cycle while the receiver
// takes responses, since the decode and update between the two registers
// are combinational.
// Reset (synchronous, active low) loads the documented reset values into every
// register of the register file and empties both pipeline stages.
// When the receiver stalls, the output register holds its response, the input
// register still takes one more request if it is empty, and s_axis_tready then
// drops until the response is taken.
module pci_host_bridge_register_file
    import pcihb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: word_index [9:0], write_data [41:10], zero fill [47:42]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: action (0 read, 1 write)
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: read_data [31:0], io_window_start [63:32], io_window_length [95:64],
    //        io_window_mapped [96], decode_changed [97], zero fill [103:98]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic        r_in_valid;
    logic        r_action;
    t_word       r_word;
    logic [31:0] r_wdata;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [31:0] r_cpu;
    t_low        r_low   [NWIN];
    t_high       r_high  [NWIN];
    t_remap      r_remap [NWIN];
    logic [31:0] r_cmd   [2];
    logic [31:0] r_sdram [4];
    logic [31:0] r_cfgaddr;

    logic [31:0] n_cpu;
    t_low        n_low   [NWIN];
    t_high       n_high  [NWIN];
    t_remap      n_remap [NWIN];
    logic [31:0] n_cmd   [2];
    logic [31:0] n_sdram [4];
    logic [31:0] n_cfgaddr;

    logic        w_advance;
    logic        w_fire;
    logic [31:0] w_data;
    logic [1:0]  w_sdram_off;
    logic        w_is_sdram;
    logic        w_changed;
    logic [31:0] w_rd_raw;
    logic [31:0] w_rd;
    logic [10:0] w_len11;
    logic [31:0] w_start;
    logic [31:0] w_len;
    logic        w_mapped;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_data      = BIG_ENDIAN ? swap32(r_wdata) : r_wdata;
    assign w_sdram_off = 2'(r_word - W_SDRAM0);
    assign w_is_sdram  = (r_word >= W_SDRAM0) && (r_word <= W_SDRAM3);

    // Register update for a write.
    always_comb begin
        n_cpu     = r_cpu;
        n_low     = r_low;
        n_high    = r_high;
        n_remap   = r_remap;
        n_cmd     = r_cmd;
        n_sdram   = r_sdram;
        n_cfgaddr = r_cfgaddr;
        w_changed = 1'b0;
        if (r_action == ACT_WRITE) begin
            for (int i = 0; i < NWIN; i++) begin
                if (r_word == LOW_WORD[i]) begin
                    n_low[i]   = w_data[14:0];
                    n_remap[i] = w_data[10:0];
                    w_changed  = 1'b1;
                end
                if (r_word == HIGH_WORD[i]) begin
                    n_high[i] = w_data[6:0];
                    w_changed = 1'b1;
                end
                if (r_word == REMAP_WORD[i]) begin
                    n_remap[i] = w_data[10:0];
                    w_changed  = 1'b1;
                end
            end
            if (w_is_sdram) begin
                n_sdram[w_sdram_off] = w_data;
            end
            case (r_word)
                W_CPU:     n_cpu     = w_data;
                W_CMD0:    n_cmd[0]  = w_data & CMD_MASK;
                W_CMD1:    n_cmd[1]  = w_data & CMD_MASK;
                W_CFGADDR: n_cfgaddr = w_data & CFGADDR_MASK;
                default:   ;
            endcase
        end
    end

    // Readback. The window words never overlap the fixed ones, so the order
    // of the tests does not matter.
    always_comb begin
        case (r_word)
            W_CPU:                   w_rd_raw = r_cpu;
            W_SYNC0, W_SYNC1:        w_rd_raw = SYNC_VALUE;
            W_ERR_DLO, W_ERR_DHI:    w_rd_raw = ERR_DATA;
            W_ERR_PAR:               w_rd_raw = ERR_PARITY;
            W_ERR_ALO, W_ERR_AHI:    w_rd_raw = 32'h0;
            W_CMD0:                  w_rd_raw = r_cmd[0];
            W_CMD1:                  w_rd_raw = r_cmd[1];
            W_CFGADDR:               w_rd_raw = r_cfgaddr;
            default:                 w_rd_raw = 32'h0;
        endcase
        if (w_is_sdram) begin
            w_rd_raw = r_sdram[w_sdram_off];
        end
        for (int i = 0; i < NWIN; i++) begin
            if (r_word == LOW_WORD[i]) begin
                w_rd_raw = {17'h0, r_low[i]};
            end
            if (r_word == HIGH_WORD[i]) begin
                w_rd_raw = {25'h0, r_high[i]};
            end
            if (r_word == REMAP_WORD[i]) begin
                w_rd_raw = {21'h0, r_remap[i]};
            end
        end
    end

    assign w_rd = (r_action == ACT_WRITE) ? 32'h0
                : (BIG_ENDIAN ? swap32(w_rd_raw) : w_rd_raw);

    // The window decode reflects the state after this access.
    assign w_len11  = ({4'h0, n_high[0]} + 11'd1) - {4'h0, n_low[0][6:0]};
    assign w_start  = {n_low[0][10:0], 21'h0};
    assign w_len    = {w_len11, 21'h0};
    assign w_mapped = (w_len <= MAP_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cpu       <= CPU_RESET;
            for (int i = 0; i < NWIN; i++) begin
                r_low[i]   <= LOW_RESET[i];
                r_high[i]  <= HIGH_RESET[i];
                r_remap[i] <= LOW_RESET[i][10:0];
            end
            r_cmd[0]  <= CMD_RESET;
            r_cmd[1]  <= CMD_RESET;
            for (int i = 0; i < 4; i++) begin
                r_sdram[i] <= SDRAM_RESET;
            end
            r_cfgaddr <= 32'h0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_cpu     <= n_cpu;
                r_low     <= n_low;
                r_high    <= n_high;
                r_remap   <= n_remap;
                r_cmd     <= n_cmd;
                r_sdram   <= n_sdram;
                r_cfgaddr <= n_cfgaddr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_action <= s_axis_tuser;
            r_word   <= s_axis_tdata[9:0];
            r_wdata  <= s_axis_tdata[41:10];
        end
        if (w_fire) begin
            r_out_data <= {6'h0, w_changed, w_mapped, w_len, w_start, w_rd};
        end
    end

endmodule
